>>> rtl/calendar_day_step_weekday_unit_macros.svh
// assertion helpers for the date stepper rtl
`ifndef CALENDAR_DAY_STEP_WEEKDAY_UNIT_MACROS_SVH
`define CALENDAR_DAY_STEP_WEEKDAY_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define CDSW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define CDSW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cdsw_pkg.sv
`timescale 1ns / 1ps

package cdsw_pkg;

	localparam logic [13:0] YEAR_MIN  = 14'd1;
	localparam logic [13:0] YEAR_MAX  = 14'd9999;
	localparam logic [3:0]  MONTH_JAN = 4'd1;
	localparam logic [3:0]  MONTH_FEB = 4'd2;
	localparam logic [3:0]  MONTH_DEC = 4'd12;
	localparam logic        CMD_NEXT  = 1'b0;
	localparam logic        CMD_PREV  = 1'b1;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_t;

	typedef struct packed {
		logic range_err;
		logic no_date;
	} step_flags_t;

	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		unique case (mon)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return len;
	endfunction

	// (13*mm - 1) / 5 with march as month one
	function automatic logic [4:0] month_offset(input logic [3:0] mon);
		logic [4:0] ofs;
		unique case (mon)
			4'd1:    ofs = 5'd28;
			4'd2:    ofs = 5'd31;
			4'd3:    ofs = 5'd2;
			4'd4:    ofs = 5'd5;
			4'd5:    ofs = 5'd7;
			4'd6:    ofs = 5'd10;
			4'd7:    ofs = 5'd12;
			4'd8:    ofs = 5'd15;
			4'd9:    ofs = 5'd18;
			4'd10:   ofs = 5'd20;
			4'd11:   ofs = 5'd23;
			4'd12:   ofs = 5'd25;
			default: ofs = 5'd0;
		endcase
		return ofs;
	endfunction

endpackage

>>> rtl/calendar_day_step_weekday_unit.sv
`timescale 1ns / 1ps
// channel  handshake              word
// in       in_valid / in_ready    command, year, month, day
// out      out_valid / out_ready  new_year, new_month, new_day, weekday, range_error
//
// one word per cycle unless held; out_valid rises once a word passes s1-s3 into s4
// stages: input register, day step, weekday partial sum and year/100, result
// reset clears the stage valid bits only
// a held result (out_valid without out_ready) freezes every stage and drops in_ready

`include "calendar_day_step_weekday_unit_macros.svh"

module calendar_day_step_weekday_unit
	import cdsw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [13:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] new_year,
	output logic [3:0]  new_month,
	output logic [4:0]  new_day,
	output logic [2:0]  weekday,
	output logic        range_error
);

	logic        en;
	logic        valid_s1;
	logic        valid_s2;
	logic        valid_s3;
	logic        valid_s4;
	logic        cmd_s1;
	date_t       date_s1;
	date_t       step_date;
	step_flags_t step_flags;
	date_t       date_s2;
	step_flags_t flags_s2;
	date_t       date_s3;
	logic        err_s3;
	date_t       date_s4;
	logic        err_s4;
	logic [2:0]  weekday_s4;

	assign en       = !valid_s4 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1   <= command;
			date_s1  <= '{year: year, month: month, day: day};
			date_s2  <= step_date;
			flags_s2 <= step_flags;
			date_s3  <= date_s2;
			err_s3   <= flags_s2.range_err;
			date_s4  <= date_s3;
			err_s4   <= err_s3;
		end
	end

	cdsw_step u_step (
		.command (cmd_s1),
		.din     (date_s1),
		.dout    (step_date),
		.flags   (step_flags)
	);

	cdsw_wday u_wday (
		.clk        (clk),
		.en         (en),
		.date       (date_s2),
		.no_date    (flags_s2.no_date),
		.weekday_s4 (weekday_s4)
	);

	assign out_valid   = valid_s4;
	assign new_year    = date_s4.year;
	assign new_month   = date_s4.month;
	assign new_day     = date_s4.day;
	assign weekday     = weekday_s4;
	assign range_error = err_s4;

	`CDSW_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, valid_s1,
		"accepted word did not enter the input stage")
	`CDSW_ASSERT_NEXT(a_stage_advance, valid_s3 && en, out_valid,
		"word lost between last stage and result")
	`CDSW_ASSERT_NOW(a_weekday_range, out_valid, weekday != 3'd7,
		"weekday out of range")
	`CDSW_ASSERT_NOW(a_month_day_sane, out_valid && !range_error,
		(new_month != 4'd0) && (new_month <= MONTH_DEC) && (new_day != 5'd0),
		"stepped date has no valid month or day")
	`CDSW_ASSERT_NOW(a_feb_len, out_valid && !range_error && (new_month == MONTH_FEB),
		new_day <= 5'd29, "february day beyond 29")

endmodule

>>> rtl/cdsw_step.sv
`timescale 1ns / 1ps

module cdsw_step
	import cdsw_pkg::*;
(
	input  logic        command,
	input  date_t       din,
	output date_t       dout,
	output step_flags_t flags
);

	logic [23:0] inv_prod;
	logic        div100;
	logic        div400;
	logic        leap;
	logic        bad;
	logic        err;
	logic [3:0]  prev_month;
	logic [4:0]  len;
	logic [4:0]  prev_len;

	// year/4 divisible by 25 iff times the inverse of 25 mod 2^12 stays small
	assign inv_prod = {12'd0, din.year[13:2]} * 24'd3113;
	assign div100   = (din.year[1:0] == 2'b00) && (inv_prod[11:0] <= 12'd163);
	assign div400   = div100 && (din.year[3:2] == 2'b00);
	assign leap     = (din.year[1:0] == 2'b00) && (!div100 || div400);

	assign prev_month = din.month - 4'd1;
	assign len        = month_len(din.month, leap);
	assign prev_len   = month_len(prev_month, leap);

	assign bad = (din.year < YEAR_MIN) || (din.year > YEAR_MAX) ||
		(din.month < MONTH_JAN) || (din.month > MONTH_DEC);

	always_comb begin
		dout = din;
		err  = 1'b0;
		if (bad) begin
			err = 1'b1;
		end else if (command == CMD_NEXT) begin
			if ((din.day != 5'd0) && (din.day < len)) begin
				dout.day = din.day + 5'd1;
			end else if (din.month < MONTH_DEC) begin
				dout.day   = 5'd1;
				dout.month = din.month + 4'd1;
			end else if (din.year < YEAR_MAX) begin
				dout.day   = 5'd1;
				dout.month = MONTH_JAN;
				dout.year  = din.year + 14'd1;
			end else begin
				err = 1'b1;
			end
		end else begin
			if ((din.day >= 5'd2) && (din.day <= len)) begin
				dout.day = din.day - 5'd1;
			end else if (din.month > MONTH_JAN) begin
				dout.month = prev_month;
				dout.day   = prev_len;
			end else if (din.year > YEAR_MIN) begin
				dout.year  = din.year - 14'd1;
				dout.month = MONTH_DEC;
				dout.day   = 5'd31;
			end else begin
				err = 1'b1;
			end
		end
	end

	assign flags.range_err = err;
	assign flags.no_date   = bad;

endmodule

>>> rtl/cdsw_wday.sv
`timescale 1ns / 1ps

module cdsw_wday
	import cdsw_pkg::*;
(
	input  logic       clk,
	input  logic       en,
	input  date_t      date,
	input  logic       no_date,
	output logic [2:0] weekday_s4
);

	logic        shift;
	logic [13:0] yy;
	logic [13:0] partial;
	logic [26:0] q_prod;
	logic [13:0] partial_s3;
	logic [6:0]  q100_s3;
	logic        no_date_s3;
	logic [13:0] sum;
	logic [4:0]  fold1;
	logic [3:0]  fold2;
	logic [2:0]  fold3;
	logic [2:0]  wd;

	// january and february count as months of the year before
	assign shift   = (date.month <= MONTH_FEB);
	assign yy      = date.year - {13'd0, shift};
	assign partial = {9'd0, date.day} + {9'd0, month_offset(date.month)} + yy +
		{2'b00, yy[13:2]};
	// yy / 100 by reciprocal; the 7-bit quotient is exact for yy below 12800
	assign q_prod  = {13'd0, yy} * 27'd5243;

	always_ff @(posedge clk) begin
		if (en) begin
			partial_s3 <= partial;
			q100_s3    <= q_prod[25:19];
			no_date_s3 <= no_date;
		end
	end

	assign sum = partial_s3 - {7'd0, q100_s3} + {9'd0, q100_s3[6:2]};

	// mod 7 by folding octal digits, since 8 is 1 mod 7
	assign fold1 = {2'b00, sum[2:0]} + {2'b00, sum[5:3]} + {2'b00, sum[8:6]} +
		{2'b00, sum[11:9]} + {3'b000, sum[13:12]};
	assign fold2 = {1'b0, fold1[2:0]} + {2'b00, fold1[4:3]};
	assign fold3 = fold2[2:0] + {2'b00, fold2[3]};
	assign wd    = (fold3 == 3'd7) ? 3'd0 : fold3;

	always_ff @(posedge clk) begin
		if (en) begin
			weekday_s4 <= no_date_s3 ? 3'd0 : wd;
		end
	end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cdsw_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD    = 150;

	typedef struct {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  wday;
		logic        err;
	} stepped_date_t;

	class date_step_board;
		stepped_date_t stepped_q[$];
		int n_errors;

		function new();
			n_errors = 0;
		endfunction

		function bit is_leap(int y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		// invalid months count as 31 days
		function int month_days(int y, int m);
			case (m)
				MONTH_FEB:       return is_leap(y) ? 29 : 28;
				4, 6, 9, 11:     return 30;
				default:         return 31;
			endcase
		endfunction

		// zeller congruence with march as month one, 0 is sunday
		function int weekday_for(int y, int m, int d);
			int sh;
			int mm;
			int yy;
			int s;
			sh = (m <= MONTH_FEB) ? 1 : 0;
			mm = m + 12 * sh - 2;
			yy = y - sh;
			s = d + (13 * mm - 1) / 5 + yy + yy / 4 - yy / 100 + yy / 400;
			return s % 7;
		endfunction

		function stepped_date_t step_date(logic cmd, int y, int m, int d);
			stepped_date_t r;
			int len;
			r.year = 14'(y);
			r.month = 4'(m);
			r.day = 5'(d);
			r.wday = 0;
			r.err = 1'b0;
			// bad year or month: echo the date, weekday stays zero
			if (y < YEAR_MIN || y > YEAR_MAX || m < MONTH_JAN || m > MONTH_DEC) begin
				r.err = 1'b1;
				return r;
			end
			len = month_days(y, m);
			if (cmd == CMD_NEXT) begin
				if (d >= 1 && d < len) begin
					r.day = 5'(d + 1);
				end else if (m < MONTH_DEC) begin
					r.day = 1;
					r.month = 4'(m + 1);
				end else if (y < YEAR_MAX) begin
					r.day = 1;
					r.month = MONTH_JAN;
					r.year = 14'(y + 1);
				end else begin
					r.err = 1'b1;
				end
			end else begin
				if (d >= 2 && d <= len) begin
					r.day = 5'(d - 1);
				end else if (m > MONTH_JAN) begin
					r.month = 4'(m - 1);
					r.day = 5'(month_days(y, m - 1));
				end else if (y > YEAR_MIN) begin
					r.year = 14'(y - 1);
					r.month = MONTH_DEC;
					r.day = 31;
				end else begin
					r.err = 1'b1;
				end
			end
			r.wday = 3'(weekday_for(r.year, r.month, r.day));
			return r;
		endfunction

		function void note_word(logic cmd, logic [13:0] y, logic [3:0] m, logic [4:0] d);
			stepped_q.push_back(step_date(cmd, y, m, d));
		endfunction

		function void cmp_field(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				n_errors++;
			end
		endfunction

		function void check_word(logic [13:0] y, logic [3:0] m, logic [4:0] d,
			logic [2:0] w, logic e);
			stepped_date_t want;
			if (stepped_q.size() == 0) begin
				$error("unexpected word %0d-%0d-%0d", y, m, d);
				n_errors++;
				return;
			end
			want = stepped_q.pop_front();
			cmp_field("new_year", want.year, y);
			cmp_field("new_month", want.month, m);
			cmp_field("new_day", want.day, d);
			cmp_field("weekday", want.wday, w);
			cmp_field("range_error", want.err, e);
		endfunction

		function int pending();
			return stepped_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic        out_valid;
	logic        out_ready;
	logic [13:0] new_year;
	logic [3:0]  new_month;
	logic [4:0]  new_day;
	logic [2:0]  weekday;
	logic        range_error;

	date_step_board sb = new();
	bit steady = 1'b0;
	int hold_req = 0;

	calendar_day_step_weekday_unit i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_word(logic c, logic [13:0] y, logic [3:0] m, logic [4:0] d);
		while (!steady && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		year <= y;
		month <= m;
		day <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_word(c, y, m, d);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic run_directed();
		send_word(CMD_NEXT, YEAR_MAX, MONTH_DEC, 31);
		send_word(CMD_PREV, YEAR_MIN, MONTH_JAN, 1);
		send_word(CMD_NEXT, YEAR_MIN, MONTH_JAN, 1);
		send_word(CMD_PREV, YEAR_MAX, MONTH_DEC, 31);
		send_word(CMD_NEXT, 2000, MONTH_FEB, 28);
		send_word(CMD_NEXT, 1900, MONTH_FEB, 28);
		send_word(CMD_PREV, 2000, 3, 1);
		send_word(CMD_PREV, 2100, 3, 1);
		send_word(CMD_PREV, 2023, 5, 1);
		send_word(CMD_NEXT, 2023, MONTH_DEC, 31);
		send_word(CMD_PREV, 2024, MONTH_JAN, 1);
		send_word(CMD_NEXT, 0, 6, 15);
		send_word(CMD_PREV, 14'h3fff, 6, 15);
		send_word(CMD_NEXT, 2024, 0, 10);
		send_word(CMD_PREV, 2024, 4'hf, 31);
		send_word(CMD_NEXT, 2024, 13, 1);
		send_word(CMD_NEXT, 2024, 7, 0);
		send_word(CMD_PREV, 2024, 7, 0);
		send_word(CMD_NEXT, 2023, 4, 31);
		send_word(CMD_PREV, 2023, 4, 31);
		send_word(CMD_PREV, 2023, MONTH_FEB, 30);
		send_word(CMD_NEXT, 1999, 8, 17);
		send_word(CMD_PREV, 1999, 8, 17);
	endtask

	// valid dates dominate, with month ends, leap centuries and bad fields mixed in
	task automatic send_random(int n);
		logic c;
		int y;
		int m;
		int d;
		int len;
		int pick;
		for (int i = 0; i < n; i++) begin
			c = 1'($urandom_range(1));
			pick = $urandom_range(99);
			if (pick < 4)
				y = $urandom_range(1) ? 0 : $urandom_range(16383, 10000);
			else if (pick < 10)
				y = $urandom_range(1) ? YEAR_MIN : YEAR_MAX;
			else if (pick < 30)
				y = $urandom_range(99, 1) * 100;
			else
				y = $urandom_range(9999, 1);
			pick = $urandom_range(99);
			if (pick < 4)
				m = $urandom_range(15);
			else if (pick < 20)
				case ($urandom_range(2))
					0:       m = MONTH_JAN;
					1:       m = MONTH_FEB;
					default: m = MONTH_DEC;
				endcase
			else
				m = $urandom_range(12, 1);
			len = sb.month_days(y, m);
			pick = $urandom_range(99);
			if (pick < 8)
				d = $urandom_range(31);
			else if (pick < 30)
				d = len - $urandom_range(1);
			else if (pick < 45)
				d = 1 + $urandom_range(1);
			else
				d = $urandom_range(len, 1);
			send_word(c, 14'(y), 4'(m), 5'(d));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_NEXT;
		year <= YEAR_MIN;
		month <= MONTH_JAN;
		day <= 5'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		send_random(400);
		wait_drained();
		// receiver holds off while words keep coming, so the pipe backs up
		steady = 1'b1;
		hold_req = LONG_HOLD;
		send_random(60);
		send_random(300);
		steady = 1'b0;
		send_random(420);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.n_errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_word(new_year, new_month, new_day, weekday, range_error);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 11);
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("testbench failed");
		$finish;
	end

endmodule
